// File: rtl/core/hrrn_pkg.sv
// Shared types and constants for the HRRN job scheduler.
// Used by the interfaces, the job cells, the selector and the top level.
`default_nettype none

package hrrn_pkg;

  localparam int unsigned JOBS_DEF = 16;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned WPR_W  = TIME_W + 1;
  localparam int unsigned PROD_W = WPR_W + TIME_W;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [SIZE_W-1:0] MEM_TOTAL_RST  = 17'd65536;
  localparam logic [CNT_W-1:0]  TAPE_TOTAL_RST = 4'd4;
  localparam logic [CNT_W-1:0]  PRN_TOTAL_RST  = 4'd2;

  typedef enum logic [1:0] {
    REG_MEM  = 2'd0,
    REG_TAPE = 2'd1,
    REG_PRN  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DECIDE = 2'd2
  } state_e;

  // wpr holds wait + run, run is never zero once stored
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  tape;
    logic [CNT_W-1:0]  prn;
    logic [WPR_W-1:0]  wpr;
    logic [TIME_W-1:0] run;
  } job_t;

  typedef struct packed {
    logic shift;
    logic kill;
    logic flush;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic eval;
    logic commit;
  } sel_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/hrrn_ifs.sv
// Valid/ready channel interfaces for job words in and result words out.
// Depends on hrrn_pkg for field widths.
`default_nettype none

interface hrrn_job_if
  import hrrn_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   job_id;
  logic [SIZE_W-1:0] job_size;
  logic [CNT_W-1:0]  tape_need;
  logic [CNT_W-1:0]  printer_need;
  logic [TIME_W-1:0] wait_time;
  logic [TIME_W-1:0] run_time;
  logic              last_job;

  modport source (
    output valid, job_id, job_size, tape_need, printer_need, wait_time, run_time,
           last_job,
    input  ready
  );
  modport sink (
    input  valid, job_id, job_size, tape_need, printer_need, wait_time, run_time,
           last_job,
    output ready
  );
endinterface

interface hrrn_res_if
  import hrrn_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] chosen_id;
  logic            chosen_valid;
  logic            last_result;

  modport source (
    output valid, chosen_id, chosen_valid, last_result,
    input  ready
  );
  modport sink (
    input  valid, chosen_id, chosen_valid, last_result,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/hrrn_job_scheduler_unit.sv
// Load: one job word per cycle while in the load state. Each selection rotates the
// JOBS-cell chain once past the head selector, with an evaluate step and a commit step
// per cell, then a decide step. The first pick leaves on the second decide. One batch
// at a time.
// Reset clears valid bits, counters and handshake state; config registers take reset values.
// Top level: APB config port, job channel in, result channel out. Uses hrrn_pkg, cells, sel.
`default_nettype none

module hrrn_job_scheduler_unit
  import hrrn_pkg::*;
#(
  parameter int unsigned JOBS = JOBS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [PADDR_W-1:0]  paddr,
  input  wire  [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  hrrn_job_if.sink            job_i,
  hrrn_res_if.source          res_o
);

  localparam int unsigned IW = $clog2(JOBS);
  localparam int unsigned CW = $clog2(JOBS + 1);

  // config registers
  logic [SIZE_W-1:0] cfg_mem_q;
  logic [CNT_W-1:0]  cfg_tape_q, cfg_prn_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mem_q  <= MEM_TOTAL_RST;
      cfg_tape_q <= TAPE_TOTAL_RST;
      cfg_prn_q  <= PRN_TOTAL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MEM:  cfg_mem_q  <= pwdata[SIZE_W-1:0];
        REG_TAPE: cfg_tape_q <= pwdata[CNT_W-1:0];
        REG_PRN:  cfg_prn_q  <= pwdata[CNT_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MEM:  prdata = PDATA_W'(cfg_mem_q);
      REG_TAPE: prdata = PDATA_W'(cfg_tape_q);
      REG_PRN:  prdata = PDATA_W'(cfg_prn_q);
      default:  prdata = '0;
    endcase
  end

  // control state
  state_e            st_q, st_d;
  logic              phase_q, phase_d;
  logic [IW-1:0]     step_q, step_d;
  logic [CW-1:0]     count_q, count_d;
  logic [SIZE_W-1:0] mem_q, mem_d;
  logic [CNT_W-1:0]  tape_q, tape_d, prn_q, prn_d;
  logic              pend_v_q, pend_v_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic              out_v_q, out_v_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_cv_q, out_cv_d, out_last_q, out_last_d;
  logic              push, can_push, in_acc;
  logic              shift, load_sel, kill_en, flush;
  sel_ctrl_t         sel_ctrl;

  // chain
  job_t              cell_job [JOBS];
  logic [JOBS-1:0]   cell_vld;
  job_t              new_job;
  logic [TIME_W-1:0] run_adj;
  logic              found;
  job_t              best;
  logic [IW-1:0]     best_pos;
  logic [IW-1:0]     kill_idx;

  assign job_i.ready = (st_q == ST_LOAD);
  assign in_acc      = job_i.valid && job_i.ready;
  assign can_push    = !out_v_q || res_o.ready;

  assign run_adj      = (job_i.run_time == '0) ? TIME_W'(1) : job_i.run_time;
  assign new_job.id   = job_i.job_id;
  assign new_job.size = job_i.job_size;
  assign new_job.tape = job_i.tape_need;
  assign new_job.prn  = job_i.printer_need;
  assign new_job.wpr  = WPR_W'(job_i.wait_time) + WPR_W'(run_adj);
  assign new_job.run  = run_adj;

  assign kill_idx = IW'(JOBS - 1) - best_pos;

  always_comb begin
    st_d       = st_q;
    phase_d    = phase_q;
    step_d     = step_q;
    count_d    = count_q;
    mem_d      = mem_q;
    tape_d     = tape_q;
    prn_d      = prn_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    push       = 1'b0;
    out_id_d   = out_id_q;
    out_cv_d   = out_cv_q;
    out_last_d = out_last_q;
    shift      = 1'b0;
    load_sel   = 1'b0;
    kill_en    = 1'b0;
    flush      = 1'b0;
    sel_ctrl   = '0;
    case (st_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_q < CW'(JOBS)) begin
            shift    = 1'b1;
            load_sel = 1'b1;
            count_d  = count_q + CW'(1);
          end
          if (job_i.last_job) begin
            mem_d          = cfg_mem_q;
            tape_d         = cfg_tape_q;
            prn_d          = cfg_prn_q;
            pend_v_d       = 1'b0;
            sel_ctrl.clear = 1'b1;
            step_d         = '0;
            phase_d        = 1'b0;
            st_d           = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!phase_q) begin
          sel_ctrl.eval = 1'b1;
          phase_d       = 1'b1;
        end else begin
          sel_ctrl.commit = 1'b1;
          shift           = 1'b1;
          phase_d         = 1'b0;
          step_d          = step_q + IW'(1);
          if (step_q == IW'(JOBS - 1)) begin
            st_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (found) begin
          if (!pend_v_q || can_push) begin
            if (pend_v_q) begin
              push       = 1'b1;
              out_id_d   = pend_id_q;
              out_cv_d   = 1'b1;
              out_last_d = 1'b0;
            end
            pend_v_d       = 1'b1;
            pend_id_d      = best.id;
            mem_d          = mem_q - best.size;
            tape_d         = tape_q - best.tape;
            prn_d          = prn_q - best.prn;
            kill_en        = 1'b1;
            sel_ctrl.clear = 1'b1;
            step_d         = '0;
            phase_d        = 1'b0;
            st_d           = ST_SCAN;
          end
        end else if (can_push) begin
          push       = 1'b1;
          out_id_d   = pend_v_q ? pend_id_q : '0;
          out_cv_d   = pend_v_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          flush      = 1'b1;
          count_d    = '0;
          st_d       = ST_LOAD;
        end
      end
      default: st_d = ST_LOAD;
    endcase
    out_v_d = push ? 1'b1 : (res_o.ready ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_LOAD;
      phase_q  <= 1'b0;
      step_q   <= '0;
      count_q  <= '0;
      mem_q    <= MEM_TOTAL_RST;
      tape_q   <= TAPE_TOTAL_RST;
      prn_q    <= PRN_TOTAL_RST;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      phase_q  <= phase_d;
      step_q   <= step_d;
      count_q  <= count_d;
      mem_q    <= mem_d;
      tape_q   <= tape_d;
      prn_q    <= prn_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q  <= pend_id_d;
    out_id_q   <= out_id_d;
    out_cv_q   <= out_cv_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid        = out_v_q;
  assign res_o.chosen_id    = out_id_q;
  assign res_o.chosen_valid = out_cv_q;
  assign res_o.last_result  = out_last_q;

  // new jobs enter cell 0; during a scan the head feeds back into cell 0
  for (genvar g = 0; g < JOBS; g++) begin : g_cell
    cell_ctrl_t ctrl;
    job_t       din;
    logic       vin;

    assign ctrl.shift = shift;
    assign ctrl.kill  = kill_en && (kill_idx == IW'(g));
    assign ctrl.flush = flush;

    if (g == 0) begin : g_first
      assign din = load_sel ? new_job : cell_job[JOBS-1];
      assign vin = load_sel ? 1'b1 : cell_vld[JOBS-1];
    end else begin : g_rest
      assign din = cell_job[g-1];
      assign vin = cell_vld[g-1];
    end

    hrrn_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .job_i   (din),
      .valid_i (vin),
      .job_o   (cell_job[g]),
      .valid_o (cell_vld[g])
    );
  end

  hrrn_sel #(
    .JOBS (JOBS)
  ) u_sel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (sel_ctrl),
    .step_i       (step_q),
    .head_i       (cell_job[JOBS-1]),
    .head_valid_i (cell_vld[JOBS-1]),
    .mem_left_i   (mem_q),
    .tape_left_i  (tape_q),
    .prn_left_i   (prn_q),
    .found_o      (found),
    .best_o       (best),
    .best_pos_o   (best_pos)
  );

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(JOBS))
    else $error("job count above capacity");

  a_valid_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) <= int'(count_q))
    else $error("more valid cells than loaded jobs");

  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DECIDE && st_d == ST_LOAD) |=> (cell_vld == '0 && count_q == '0))
    else $error("chain not emptied at end of batch");

  a_pick_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DECIDE && found) |->
      (best.size <= mem_q && best.tape <= tape_q && best.prn <= prn_q))
    else $error("picked job does not fit");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.chosen_valid) |-> res_o.last_result)
    else $error("empty result not marked last");
`endif

endmodule

`default_nettype wire

// File: rtl/core/hrrn_cell.sv
// One job slot of the rotating job chain.
// Depends on hrrn_pkg for job_t and cell_ctrl_t.
`default_nettype none

module hrrn_cell
  import hrrn_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  job_t       job_i,
  input  wire        valid_i,
  output job_t       job_o,
  output logic       valid_o
);

  job_t job_q;
  logic valid_q, valid_d;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.flush || ctrl_i.kill) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      job_q <= job_i;
    end
  end

  assign job_o   = job_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: rtl/core/hrrn_sel.sv
// Best-job tracker at the head of the chain: fit check and ratio compare.
// Depends on hrrn_pkg; each cell is handled in a multiply step, then a compare step.
`default_nettype none

module hrrn_sel
  import hrrn_pkg::*;
#(
  parameter int unsigned JOBS = JOBS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  sel_ctrl_t                   ctrl_i,
  input  wire  [$clog2(JOBS)-1:0]     step_i,
  input  job_t                        head_i,
  input  wire                         head_valid_i,
  input  wire  [SIZE_W-1:0]           mem_left_i,
  input  wire  [CNT_W-1:0]            tape_left_i,
  input  wire  [CNT_W-1:0]            prn_left_i,
  output logic                        found_o,
  output job_t                        best_o,
  output logic [$clog2(JOBS)-1:0]     best_pos_o
);

  localparam int unsigned IW = $clog2(JOBS);

  job_t              best_q, cand_q;
  logic [IW-1:0]     pos_q;
  logic [PROD_W-1:0] prod_cand_q, prod_best_q;
  logic              cand_ok_q;
  logic              found_q, found_d;
  logic              fits;
  logic              take;

  assign fits = (head_i.size <= mem_left_i) && (head_i.tape <= tape_left_i) &&
                (head_i.prn <= prn_left_i);

  // >= lets the later-loaded job win a tie
  assign take = ctrl_i.commit && cand_ok_q && (!found_q || (prod_cand_q >= prod_best_q));

  always_comb begin
    found_d = found_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      prod_cand_q <= PROD_W'(head_i.wpr) * PROD_W'(best_q.run);
      prod_best_q <= PROD_W'(best_q.wpr) * PROD_W'(head_i.run);
      cand_q      <= head_i;
      cand_ok_q   <= head_valid_i && fits;
    end
    if (take) begin
      best_q <= cand_q;
      pos_q  <= step_i;
    end
  end

  assign found_o    = found_q;
  assign best_o     = best_q;
  assign best_pos_o = pos_q;

endmodule

`default_nettype wire
